/* rtl/assert_macros.svh */
// Assertion macros shared by the free-space map modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/pfsm_pkg.sv */
// Package for the page free-space map: sizes, operation codes and shared types.
package pfsm_pkg;

  localparam int PageCount   = 256;
  localparam int BucketSize  = 512;
  localparam int BucketCount = 16;
  localparam int PageW       = 8;
  localparam int BucketW     = 4;
  localparam int LenW        = 9;
  localparam int ShiftW      = $clog2(BucketSize);
  localparam int QueueDepth  = 2;

  localparam logic [2:0] KIND_RECORD = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_FIND   = 3'd2;
  localparam logic [2:0] KIND_QUERY  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // Operation after classification by the front part.
  typedef enum logic [2:0] {
    OP_RECORD,
    OP_REMOVE,
    OP_FIND,
    OP_QUERY,
    OP_CLEAR,
    OP_BAD
  } op_t;

  // A classified command as it travels through the queue.
  typedef struct packed {
    op_t                op;
    logic [PageW-1:0]   page;
    logic [15:0]        spare_bytes;
    logic [15:0]        fragments;
    logic [BucketW-1:0] bucket;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  found_page;
    logic [15:0] page_free;
    logic [15:0] page_fragments;
  } result_t;

  // Bucket of a byte count: a shift, clamped to the top bucket.
  function automatic logic [BucketW-1:0] bucket_of(input logic [15:0] bytes);
    logic [15:0] q;
    q = bytes >> ShiftW;
    if (q > 16'(BucketCount - 1)) begin
      return BucketW'(BucketCount - 1);
    end
    return q[BucketW-1:0];
  endfunction

endpackage

/* rtl/pfsm_stream_if.sv */
// Valid/ready channel interfaces for the input and result transactions.
interface pfsm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  page_id;
  logic [15:0] spare_bytes;
  logic [15:0] frag_cnt;
  logic [15:0] need_bytes;
  modport source (output valid, kind, page_id, spare_bytes, frag_cnt,
                  need_bytes, input ready);
  modport sink (input valid, kind, page_id, spare_bytes, frag_cnt,
                need_bytes, output ready);
endinterface

interface pfsm_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  found_page;
  logic [15:0] page_free;
  logic [15:0] page_fragments;
  modport source (output valid, status, found_page, page_free, page_fragments,
                  input ready);
  modport sink (input valid, status, found_page, page_free, page_fragments,
                output ready);
endinterface

/* rtl/pfsm_front.sv */
// Front part: accepts input transactions, classifies them and queues commands.
module pfsm_front (
  input  logic             clk,
  input  logic             rst_n,
  pfsm_in_if.sink          in_ch,
  output pfsm_pkg::cmd_t   cmd,
  output logic             cmd_valid,
  input  logic             cmd_ready
);

  pfsm_pkg::cmd_t q_r [pfsm_pkg::QueueDepth];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  pfsm_pkg::cmd_t cls;
  logic           push, pop;

  // Classify the incoming transaction.
  always_comb begin
    cls.page        = in_ch.page_id;
    cls.spare_bytes = in_ch.spare_bytes;
    cls.fragments   = in_ch.frag_cnt;
    cls.bucket      = pfsm_pkg::bucket_of(in_ch.spare_bytes);
    case (in_ch.kind)
      pfsm_pkg::KIND_RECORD: cls.op = pfsm_pkg::OP_RECORD;
      pfsm_pkg::KIND_REMOVE: cls.op = pfsm_pkg::OP_REMOVE;
      pfsm_pkg::KIND_FIND: begin
        cls.op     = pfsm_pkg::OP_FIND;
        cls.bucket = pfsm_pkg::bucket_of(in_ch.need_bytes);
      end
      pfsm_pkg::KIND_QUERY:  cls.op = pfsm_pkg::OP_QUERY;
      pfsm_pkg::KIND_CLEAR:  cls.op = pfsm_pkg::OP_CLEAR;
      default:               cls.op = pfsm_pkg::OP_BAD;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'(pfsm_pkg::QueueDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rp_r];

  // Queue pointers and occupancy.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overflow, clk, rst_n, 1'b1, cnt_r <= 2'(pfsm_pkg::QueueDepth),
               "command queue overflow")
  `ASSERT_NEXT(a_pop_empty, clk, rst_n, cnt_r == 2'd0 && !push, !pop || cnt_r != 2'd0,
               "pop from empty queue")
  `ASSERT_IMPL(a_full_stall, clk, rst_n, cnt_r == 2'(pfsm_pkg::QueueDepth), !push,
               "push into full queue")

endmodule

/* rtl/pfsm_back.sv */
// Back part: carries out commands on the page table and the bucket lists.
module pfsm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  pfsm_pkg::cmd_t  cmd,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  pfsm_out_if.source      out_ch
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ELOOK  = 9'b000000010,
    S_LAST   = 9'b000000100,
    S_MOVE   = 9'b000001000,
    S_LINK   = 9'b000010000,
    S_FBKT   = 9'b000100000,
    S_FRD    = 9'b001000000,
    S_FCHK   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  localparam int SlotAw = pfsm_pkg::BucketW + pfsm_pkg::PageW;

  // Per-page and list memories.
  logic [15:0]                 e_free_m  [pfsm_pkg::PageCount];
  logic [15:0]                 e_frag_m  [pfsm_pkg::PageCount];
  logic [pfsm_pkg::BucketW-1:0] e_bkt_m  [pfsm_pkg::PageCount];
  logic [pfsm_pkg::PageW-1:0]  e_slot_m  [pfsm_pkg::PageCount];
  logic [pfsm_pkg::PageW-1:0]  slots_m   [pfsm_pkg::PageCount * pfsm_pkg::BucketCount];
  logic [pfsm_pkg::PageCount-1:0] valid_r;
  logic [pfsm_pkg::LenW-1:0]   len_r [pfsm_pkg::BucketCount];

  state_t                      st_r;
  pfsm_pkg::cmd_t              c_r;
  pfsm_pkg::result_t           res_r;
  logic                        ov_r;
  logic [pfsm_pkg::BucketW-1:0] ob_r, fb_r;
  logic [pfsm_pkg::PageW-1:0]  os_r, last_r, fi_r;
  logic [15:0]                 rfree_r, rfrag_r;
  logic [pfsm_pkg::BucketW-1:0] rbkt_r;
  logic [pfsm_pkg::PageW-1:0]  rslot_r, rslp_r;

  // Read ports (registered).
  logic [pfsm_pkg::PageW-1:0]  e_addr;
  logic [SlotAw-1:0]           s_addr;
  logic [pfsm_pkg::LenW-1:0]   cur_len;

  assign cmd_ready    = (st_r == S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.found_page     = res_r.found_page;
  assign out_ch.page_free      = res_r.page_free;
  assign out_ch.page_fragments = res_r.page_fragments;
  assign cur_len = len_r[fb_r];

  always_comb begin
    e_addr = c_r.page;
    s_addr = {ob_r, last_r};
    case (st_r)
      S_IDLE:  e_addr = cmd.page;
      S_ELOOK: s_addr = {rbkt_r, 8'(len_r[rbkt_r] - 9'd1)};
      S_FRD:   s_addr = {fb_r, fi_r};
      // Keep the scanned entry in the slot read register while its fragments are read.
      S_FCHK: begin
        e_addr = rslp_r;
        s_addr = {fb_r, fi_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rfree_r <= e_free_m[e_addr];
    rfrag_r <= e_frag_m[e_addr];
    rbkt_r  <= e_bkt_m[e_addr];
    rslot_r <= e_slot_m[e_addr];
    rslp_r  <= slots_m[s_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ov_r    <= 1'b0;
      valid_r <= '0;
      for (int b = 0; b < pfsm_pkg::BucketCount; b++) len_r[b] <= '0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            c_r   <= cmd;
            res_r.found_page     <= '0;
            res_r.page_free      <= '0;
            res_r.page_fragments <= '0;
            fb_r  <= cmd.bucket;
            case (cmd.op)
              pfsm_pkg::OP_CLEAR: begin
                valid_r <= '0;
                for (int b = 0; b < pfsm_pkg::BucketCount; b++) len_r[b] <= '0;
                res_r.status <= 1'b0;
                st_r <= S_DONE;
              end
              pfsm_pkg::OP_BAD: begin
                res_r.status <= 1'b1;
                st_r <= S_DONE;
              end
              pfsm_pkg::OP_FIND: begin
                res_r.status <= 1'b1;
                st_r <= S_FBKT;
              end
              default: begin
                res_r.status <= 1'b0;
                st_r <= S_ELOOK;
              end
            endcase
          end
        end
        S_ELOOK: begin
          ob_r <= rbkt_r;
          os_r <= rslot_r;
          case (c_r.op)
            pfsm_pkg::OP_QUERY: begin
              if (valid_r[c_r.page]) begin
                res_r.page_free      <= rfree_r;
                res_r.page_fragments <= rfrag_r;
              end else begin
                res_r.status <= 1'b1;
              end
              st_r <= S_DONE;
            end
            pfsm_pkg::OP_REMOVE: begin
              if (valid_r[c_r.page]) begin
                valid_r[c_r.page] <= 1'b0;
                st_r <= S_MOVE;
              end else begin
                res_r.status <= 1'b1;
                st_r <= S_DONE;
              end
            end
            default: begin
              st_r <= valid_r[c_r.page] ? S_MOVE : S_LINK;
              valid_r[c_r.page] <= 1'b1;
            end
          endcase
        end
        S_MOVE: begin
          // Swap with last: rslp_r holds the last entry of the old bucket.
          slots_m[{ob_r, os_r}] <= rslp_r;
          len_r[ob_r] <= len_r[ob_r] - 9'd1;
          if (rslp_r != c_r.page) e_slot_m[rslp_r] <= os_r;
          st_r <= (c_r.op == pfsm_pkg::OP_RECORD) ? S_LINK : S_DONE;
        end
        S_LINK: begin
          e_free_m[c_r.page] <= c_r.spare_bytes;
          e_frag_m[c_r.page] <= c_r.fragments;
          e_bkt_m[c_r.page]  <= c_r.bucket;
          e_slot_m[c_r.page] <= 8'(len_r[c_r.bucket]);
          slots_m[{c_r.bucket, 8'(len_r[c_r.bucket])}] <= c_r.page;
          len_r[c_r.bucket] <= len_r[c_r.bucket] + 9'd1;
          st_r <= S_DONE;
        end
        S_FBKT: begin
          if (cur_len != '0) begin
            fi_r <= 8'(cur_len - 9'd1);
            res_r.status <= 1'b0;
            st_r <= S_FRD;
          end else if (fb_r == pfsm_pkg::BucketW'(pfsm_pkg::BucketCount - 1)) begin
            st_r <= S_DONE;
          end else begin
            fb_r <= fb_r + pfsm_pkg::BucketW'(1);
          end
        end
        S_FRD: st_r <= S_FCHK;
        S_FCHK: begin
          // rslp_r is the slot entry; rfrag_r for it is registered and ready in S_LAST.
          if (fi_r == 8'(cur_len - 9'd1)) res_r.found_page <= rslp_r;
          st_r <= S_LAST;
        end
        S_LAST: begin
          if (rfrag_r == 16'd0) begin
            res_r.found_page <= rslp_r;
            st_r <= S_DONE;
          end else if (fi_r == '0) begin
            st_r <= S_DONE;
          end else begin
            fi_r <= fi_r - 8'd1;
            st_r <= S_FRD;
          end
        end
        S_DONE: begin
          if (!ov_r) begin
            ov_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // In S_ELOOK the last entry of the old bucket is read; capture its slot index for S_MOVE.
  always_ff @(posedge clk) begin
    if (st_r == S_ELOOK) last_r <= 8'(len_r[rbkt_r] - 9'd1);
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_onehot, clk, rst_n, 1'b1, $onehot(st_r), "state not one-hot")
  `ASSERT_IMPL(a_ready_idle, clk, rst_n, cmd_ready, st_r == S_IDLE && !ov_r,
               "command taken while busy")
  `ASSERT_NEXT(a_done_out, clk, rst_n, st_r == S_DONE && !ov_r, ov_r,
               "result not presented")

endmodule

/* rtl/page_free_space_map_top.sv */
// Top level of the page free-space map.
//   channel  | direction | content
//   in_      | input     | kind, page_id, spare_bytes, frag_cnt, need_bytes
//   out_     | output    | status, found_page, page_free, page_fragments
// Record, remove and query look up the page in S_ELOOK and may move or link it;
// clear goes straight to S_DONE. Find checks one bucket at a time in S_FBKT, then
// scans entries in S_FRD, S_FCHK and S_LAST via the single slot memory read port.
// Reset is synchronous and empties the map at once; no clearing pass follows.
// A two-entry command queue lets input transactions be taken while a result waits.
module page_free_space_map_top (
  input  logic       clk,
  input  logic       rst_n,
  pfsm_in_if.sink    in_ch,
  pfsm_out_if.source out_ch
);

  pfsm_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready;

  pfsm_front u_front (
    .clk, .rst_n, .in_ch, .cmd, .cmd_valid, .cmd_ready
  );

  pfsm_back u_back (
    .clk, .rst_n, .cmd, .cmd_valid, .cmd_ready, .out_ch
  );

endmodule
